>>> rtl/sip_pkg.sv
package sip_pkg;

  // Coordinate width, fixed by the port structs
  localparam int COORD_BITS = 16;

  // Port field widths
  localparam int IN_W  = COORD_BITS;
  localparam int OUT_W = 32;

  typedef enum logic [1:0] {
    ST_MEET     = 2'd0,
    ST_BOX      = 2'd1,
    ST_PARALLEL = 2'd2,
    ST_OUTSIDE  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] c_x;
    logic signed [IN_W-1:0] c_y;
    logic signed [IN_W-1:0] d_x;
    logic signed [IN_W-1:0] d_y;
  } in_t;

  typedef struct packed {
    status_t                 status;
    logic signed [OUT_W-1:0] point_x;
    logic signed [OUT_W-1:0] point_y;
  } out_t;

endpackage

>>> rtl/sip_front.sv
module sip_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  sip_pkg::in_t        in_data,
  output logic                push,
  output logic [2*COORD_BITS+2*(2*COORD_BITS+3)+2*(COORD_BITS+1)+1:0] push_data
);

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;       // deltas
  localparam int PW = 2 * CW + 2;   // products
  localparam int NW = 2 * CW + 3;   // det / numerators

  function automatic logic in_unit(input logic signed [NW-1:0] num,
                                   input logic signed [NW-1:0] den);
    logic res;
    if (den > 0) begin
      res = (num >= 0) && (num <= den);
    end else begin
      res = (num <= 0) && (num >= den);
    end
    return res;
  endfunction

  logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = CW'(in_data.a_x);
  assign ay = CW'(in_data.a_y);
  assign bx = CW'(in_data.b_x);
  assign by = CW'(in_data.b_y);
  assign cx = CW'(in_data.c_x);
  assign cy = CW'(in_data.c_y);
  assign dx = CW'(in_data.d_x);
  assign dy = CW'(in_data.d_y);

  // stage 1: deltas and box test
  logic                 v1_r, box1_r, box1_nxt;
  logic signed [CW-1:0] ax1_r, ay1_r;
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, ex_r, ey_r;
  logic signed [CW-1:0] abx_hi, abx_lo, cdx_hi, cdx_lo, aby_hi, aby_lo, cdy_hi, cdy_lo;

  always_comb begin
    abx_hi = (ax > bx) ? ax : bx;
    abx_lo = (ax < bx) ? ax : bx;
    cdx_hi = (cx > dx) ? cx : dx;
    cdx_lo = (cx < dx) ? cx : dx;
    aby_hi = (ay > by) ? ay : by;
    aby_lo = (ay < by) ? ay : by;
    cdy_hi = (cy > dy) ? cy : dy;
    cdy_lo = (cy < dy) ? cy : dy;
    box1_nxt = (abx_hi < cdx_lo) || (cdx_hi < abx_lo) ||
               (aby_hi < cdy_lo) || (cdy_hi < aby_lo);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= in_take;
    end
    box1_r <= box1_nxt;
    ax1_r  <= ax;
    ay1_r  <= ay;
    d1x_r  <= DW'(bx) - DW'(ax);
    d1y_r  <= DW'(by) - DW'(ay);
    d2x_r  <= DW'(dx) - DW'(cx);
    d2y_r  <= DW'(dy) - DW'(cy);
    ex_r   <= DW'(cx) - DW'(ax);
    ey_r   <= DW'(cy) - DW'(ay);
  end

  // stage 2: cross products
  logic                 v2_r, box2_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  logic signed [DW-1:0] d1x2_r, d1y2_r;
  logic signed [PW-1:0] m_da_r, m_db_r, m_ra_r, m_rb_r, m_sa_r, m_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    box2_r <= box1_r;
    ax2_r  <= ax1_r;
    ay2_r  <= ay1_r;
    d1x2_r <= d1x_r;
    d1y2_r <= d1y_r;
    m_da_r <= PW'(d1y_r) * PW'(d2x_r);
    m_db_r <= PW'(d1x_r) * PW'(d2y_r);
    m_ra_r <= PW'(d2x_r) * PW'(ey_r);
    m_rb_r <= PW'(d2y_r) * PW'(ex_r);
    m_sa_r <= PW'(d1x_r) * PW'(ey_r);
    m_sb_r <= PW'(d1y_r) * PW'(ex_r);
  end

  // stage 3: determinant and line parameters
  logic                 v3_r, box3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  logic signed [DW-1:0] d1x3_r, d1y3_r;
  logic signed [NW-1:0] det_r, rnum_r, snum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    box3_r <= box2_r;
    ax3_r  <= ax2_r;
    ay3_r  <= ay2_r;
    d1x3_r <= d1x2_r;
    d1y3_r <= d1y2_r;
    det_r  <= NW'(m_da_r) - NW'(m_db_r);
    rnum_r <= NW'(m_ra_r) - NW'(m_rb_r);
    snum_r <= NW'(m_sa_r) - NW'(m_sb_r);
  end

  // classify, first failing test wins
  sip_pkg::status_t st;

  always_comb begin
    if (box3_r) begin
      st = sip_pkg::ST_BOX;
    end else if (det_r == '0) begin
      st = sip_pkg::ST_PARALLEL;
    end else if (!in_unit(rnum_r, det_r) || !in_unit(snum_r, det_r)) begin
      st = sip_pkg::ST_OUTSIDE;
    end else begin
      st = sip_pkg::ST_MEET;
    end
  end

  assign push      = v3_r;
  assign push_data = {st, ax3_r, ay3_r, rnum_r, det_r, d1x3_r, d1y3_r};

endmodule

>>> rtl/sip_queue.sv
module sip_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNW-1:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (cnt_r != CNW'(DEPTH));
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CNW'(do_push) - CNW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign full       = (cnt_r == CNW'(DEPTH));

endmodule

>>> rtl/sip_back.sv
module sip_back #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          req_valid,
  input  logic [2*COORD_BITS+2*(2*COORD_BITS+3)+2*(COORD_BITS+1)+1:0] req_data,
  output logic          out_valid,
  output sip_pkg::out_t out_data
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int NW  = 2 * CW + 3;
  localparam int RW  = NW + 1;            // partial remainder
  localparam int MW  = NW + DW;           // |rnum| * |delta|
  localparam int QW  = CW + 1 + FRAC_BITS; // quotient bits
  localparam int XW  = MW + FRAC_BITS;     // scaled dividend
  localparam int OW  = sip_pkg::OUT_W;

  logic [1:0]           st_in;
  logic signed [CW-1:0] ax_in, ay_in;
  logic signed [NW-1:0] rn_in, det_in;
  logic signed [DW-1:0] d1x_in, d1y_in;

  assign {st_in, ax_in, ay_in, rn_in, det_in, d1x_in, d1y_in} = req_data;

  logic [NW-1:0] rn_mag, det_mag;
  logic [DW-1:0] d1x_mag, d1y_mag;
  logic [XW-1:0] nx, ny;

  assign rn_mag  = rn_in[NW-1]  ? NW'(-rn_in)  : NW'(rn_in);
  assign det_mag = det_in[NW-1] ? NW'(-det_in) : NW'(det_in);
  assign d1x_mag = d1x_in[DW-1] ? DW'(-d1x_in) : DW'(d1x_in);
  assign d1y_mag = d1y_in[DW-1] ? DW'(-d1y_in) : DW'(d1y_in);

  // dividend = |rnum| * |delta| * 2^FRAC_BITS
  assign nx = XW'(MW'(rn_mag) * MW'(d1x_mag)) << FRAC_BITS;
  assign ny = XW'(MW'(rn_mag) * MW'(d1y_mag)) << FRAC_BITS;

  // divider pipeline, one quotient bit per stage; index 0 holds the products
  logic                 vld_r  [QW+1];
  sip_pkg::status_t     st_r   [QW+1];
  logic signed [CW-1:0] ax_r   [QW+1];
  logic signed [CW-1:0] ay_r   [QW+1];
  logic                 negx_r [QW+1];
  logic                 negy_r [QW+1];
  logic [NW-1:0]        d_r    [QW+1];
  logic [RW-1:0]        remx_r [QW+1];
  logic [RW-1:0]        remy_r [QW+1];
  logic [QW-1:0]        qx_r   [QW+1];
  logic [QW-1:0]        qy_r   [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= req_valid;
    end
    st_r[0]   <= sip_pkg::status_t'(st_in);
    ax_r[0]   <= ax_in;
    ay_r[0]   <= ay_in;
    negx_r[0] <= rn_in[NW-1] ^ d1x_in[DW-1] ^ det_in[NW-1];
    negy_r[0] <= rn_in[NW-1] ^ d1y_in[DW-1] ^ det_in[NW-1];
    d_r[0]    <= det_mag;
    remx_r[0] <= RW'(nx >> QW);
    remy_r[0] <= RW'(ny >> QW);
    qx_r[0]   <= nx[QW-1:0];
    qy_r[0]   <= ny[QW-1:0];
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [RW-1:0] tx, ty, remx_nxt, remy_nxt;
    logic          gex, gey;

    always_comb begin
      tx = {remx_r[k][RW-2:0], qx_r[k][QW-1]};
      ty = {remy_r[k][RW-2:0], qy_r[k][QW-1]};
      gex = (tx >= RW'(d_r[k]));
      gey = (ty >= RW'(d_r[k]));
      remx_nxt = gex ? tx - RW'(d_r[k]) : tx;
      remy_nxt = gey ? ty - RW'(d_r[k]) : ty;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      st_r[k+1]   <= st_r[k];
      ax_r[k+1]   <= ax_r[k];
      ay_r[k+1]   <= ay_r[k];
      negx_r[k+1] <= negx_r[k];
      negy_r[k+1] <= negy_r[k];
      d_r[k+1]    <= d_r[k];
      remx_r[k+1] <= remx_nxt;
      remy_r[k+1] <= remy_nxt;
      qx_r[k+1]   <= {qx_r[k][QW-2:0], gex};
      qy_r[k+1]   <= {qy_r[k][QW-2:0], gey};
    end
  end

  // floor for negative quotients, then add A << FRAC_BITS
  logic [OW-1:0] qx32, qy32, fx, fy, bx, by;
  sip_pkg::out_t out_nxt, out_data_r;
  logic          out_valid_r;

  always_comb begin
    qx32 = OW'(qx_r[QW]);
    qy32 = OW'(qy_r[QW]);
    fx = negx_r[QW] ? OW'(-(qx32 + OW'(remx_r[QW] != '0))) : qx32;
    fy = negy_r[QW] ? OW'(-(qy32 + OW'(remy_r[QW] != '0))) : qy32;
    bx = OW'(ax_r[QW]) << FRAC_BITS;
    by = OW'(ay_r[QW]) << FRAC_BITS;
    out_nxt.status = st_r[QW];
    if (st_r[QW] == sip_pkg::ST_MEET) begin
      out_nxt.point_x = bx + fx;
      out_nxt.point_y = by + fy;
    end else begin
      out_nxt.point_x = '0;
      out_nxt.point_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[QW];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/segment_intersection_point.sv
// Segment intersection point.
//
// Request channel: start / busy / in_data. A request (segments AB and CD)
// is taken at each rising edge with start high and busy low. busy only
// rises if the request queue fills, which the always-draining back end
// never lets happen, so one request per cycle is sustained.
// Result channel: out_valid / out_data. Each result is shown for exactly
// one cycle with out_valid high; the receiver cannot stall it.
// Path from request to result, in order:
//   3 front stages (deltas and box test, cross products, determinant),
//   the request queue register, 1 dividend multiply,
//   COORD_BITS + 1 + FRAC_BITS restoring-divide stages, 1 output register.
// The divider depth (one quotient bit per stage) sets the latency; the
// pipelined divider keeps throughput at one request per cycle.
// Results come out in request order. Status: meet, boxes disjoint,
// parallel, or crossing outside a segment; the point is zero unless meet.
// Reset (rst_n low, synchronous) drops all requests in flight.
module segment_intersection_point #(
  parameter int FRAC_BITS  = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  sip_pkg::in_t  in_data,
  output logic          out_valid,
  output sip_pkg::out_t out_data
);

  localparam int COORD_BITS = sip_pkg::COORD_BITS;

  // queue entry: status, A, r numerator, determinant, B - A
  localparam int EW = 2 + 2 * COORD_BITS + 2 * (2 * COORD_BITS + 3) + 2 * (COORD_BITS + 1);

  logic          take;
  logic          push, full, head_valid;
  logic [EW-1:0] push_data, head_data;

  assign take = start && !busy;
  assign busy = full;

  // front: classify each pair of segments
  sip_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (take),
    .in_data  (in_data),
    .push     (push),
    .push_data(push_data)
  );

  // decouples classification from the divide pipeline
  sip_queue #(
    .WIDTH(EW),
    .DEPTH(2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (head_valid),
    .head_valid(head_valid),
    .head_data (head_data),
    .full      (full)
  );

  // back: fixed-point crossing point through the pipelined divider
  sip_back #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(head_valid),
    .req_data (head_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

>>> rtl/sip_checker.sv
module sip_checker #(
  parameter int LAT = 39
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input sip_pkg::in_t  in_data,
  input logic          out_valid,
  input sip_pkg::out_t out_data
);

  // every request gives a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("request lost");

  // no result without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LAT !out_valid)
    else $error("spurious result");

  // point is zero unless the segments meet
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != sip_pkg::ST_MEET) |->
      (out_data.point_x == '0 && out_data.point_y == '0))
    else $error("nonzero point without meet");

  // a degenerate first segment never meets
  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.a_x == in_data.b_x && in_data.a_y == in_data.b_y)
      |-> ##LAT (out_data.status != sip_pkg::ST_MEET))
    else $error("degenerate segment reported as meeting");

endmodule

bind segment_intersection_point sip_checker #(
  .LAT(sip_pkg::COORD_BITS + FRAC_BITS + 7)
) u_sip_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_data (out_data)
);
